/* hw/rtl/assert_macros.svh */
// Concurrent assertion macros for the RTL modules; sctp_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

/* hw/rtl/sctp_pkg.sv */
// Types and constants shared by the servo command token parser modules.
`timescale 1ns / 1ps
`default_nettype none

package sctp_pkg;

  localparam int SERVO_COUNT = 32;
  localparam int TOKEN_CHARS = 6;
  localparam int LEN_W       = $clog2(TOKEN_CHARS + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;
  localparam logic [15:0] MIN_PULSE_RST = 16'd500;
  localparam logic [15:0] MAX_PULSE_RST = 16'd2500;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] SEL_NONE = 8'd255;

  // Command word indexes; pending command holds index + 1, zero for none.
  localparam logic [3:0] W_HASH   = 4'd0;
  localparam logic [3:0] W_H      = 4'd1;
  localparam logic [3:0] W_L      = 4'd2;
  localparam logic [3:0] W_P      = 4'd3;
  localparam logic [3:0] W_Q      = 4'd4;
  localparam logic [3:0] W_QC     = 4'd5;
  localparam logic [3:0] W_QP     = 4'd6;
  localparam logic [3:0] W_QV     = 4'd7;
  localparam logic [3:0] W_S      = 4'd8;
  localparam logic [3:0] W_T      = 4'd9;
  localparam logic [3:0] W_VER    = 4'd10;
  localparam logic [3:0] CMD_NONE = 4'd0;

  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_WORD,
    TOK_NUMBER
  } tok_kind_e;

  typedef enum logic [3:0] {
    ACT_NONE         = 4'd0,
    ACT_SET_WIDTH    = 4'd1,
    ACT_SET_SPEED    = 4'd2,
    ACT_LIMP         = 4'd3,
    ACT_HOLD         = 4'd4,
    ACT_MOVE_TIME    = 4'd5,
    ACT_QUERY_STATUS = 4'd6,
    ACT_QUERY_POS    = 4'd7,
    ACT_QUERY_BATT   = 4'd8,
    ACT_VERSION      = 4'd9
  } action_e;

  // One finished token (or nothing) per received byte.
  typedef struct packed {
    tok_kind_e   kind;
    logic [3:0]  word;
    logic [15:0] number;
    logic        cmd_end;
  } tok_evt_t;

  typedef struct packed {
    action_e     action;
    logic [4:0]  servo;
    logic [15:0] value;
    logic        cmd_end;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/sctp_front.sv */
// Front end: byte classification, token collection and command word matching.
`timescale 1ns / 1ps
`default_nettype none

module sctp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  output sctp_pkg::tok_evt_t  evt_o
);
  import sctp_pkg::*;

  typedef enum logic [1:0] {
    CLS_SPACE,
    CLS_DIGIT,
    CLS_OTHER
  } class_e;

  // Only the first few characters matter for matching; longer words never match.
  localparam int MATCH_CHARS = 3;
  localparam int MIDX_W      = $clog2(MATCH_CHARS);

  localparam logic [7:0] CH_HASH = "#";
  localparam logic [7:0] CH_C    = "C";
  localparam logic [7:0] CH_E    = "E";
  localparam logic [7:0] CH_H    = "H";
  localparam logic [7:0] CH_L    = "L";
  localparam logic [7:0] CH_P    = "P";
  localparam logic [7:0] CH_Q    = "Q";
  localparam logic [7:0] CH_R    = "R";
  localparam logic [7:0] CH_S    = "S";
  localparam logic [7:0] CH_T    = "T";
  localparam logic [7:0] CH_V    = "V";

  class_e           cls, prev_q, prev_d;
  logic [LEN_W-1:0] len_q, len_d, len_base;
  logic [15:0]      num_q, num_d, num_base;
  logic [7:0]       chars_q [MATCH_CHARS];
  logic [7:0]       ch_up;
  logic             changed, keep, hit;
  logic [3:0]       widx;

  always_comb begin
    if (rx_byte_i == 8'h20 || rx_byte_i inside {[8'h09:8'h0D]}) begin
      cls = CLS_SPACE;
    end else if (rx_byte_i inside {[8'h30:8'h39]}) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_OTHER;
    end
    ch_up = (rx_byte_i inside {[8'h61:8'h7A]}) ? (rx_byte_i - 8'h20) : rx_byte_i;
  end

  // Exact match of the collected word against the command list.
  always_comb begin
    hit  = 1'b0;
    widx = W_HASH;
    case (len_q)
      LEN_W'(1): begin
        hit = 1'b1;
        case (chars_q[0])
          CH_HASH: widx = W_HASH;
          CH_H:    widx = W_H;
          CH_L:    widx = W_L;
          CH_P:    widx = W_P;
          CH_Q:    widx = W_Q;
          CH_S:    widx = W_S;
          CH_T:    widx = W_T;
          default: hit = 1'b0;
        endcase
      end
      LEN_W'(2): begin
        if (chars_q[0] == CH_Q) begin
          hit = 1'b1;
          case (chars_q[1])
            CH_C:    widx = W_QC;
            CH_P:    widx = W_QP;
            CH_V:    widx = W_QV;
            default: hit = 1'b0;
          endcase
        end
      end
      LEN_W'(3): begin
        if (chars_q[0] == CH_V && chars_q[1] == CH_E && chars_q[2] == CH_R) begin
          hit  = 1'b1;
          widx = W_VER;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    changed  = (cls != prev_q);
    len_base = changed ? '0 : len_q;
    num_base = changed ? 16'd0 : num_q;
    keep     = (cls != CLS_SPACE) && (len_base < LEN_W'(TOKEN_CHARS));

    evt_o.kind    = TOK_NONE;
    evt_o.word    = widx;
    evt_o.number  = num_q;
    evt_o.cmd_end = (rx_byte_i == CH_CR);
    if (changed && prev_q == CLS_OTHER && hit) begin
      evt_o.kind = TOK_WORD;
    end else if (changed && prev_q == CLS_DIGIT) begin
      evt_o.kind = TOK_NUMBER;
    end

    prev_d = prev_q;
    len_d  = len_q;
    num_d  = num_q;
    if (accept_i) begin
      prev_d = cls;
      len_d  = len_base;
      num_d  = num_base;
      if (keep) begin
        len_d = len_base + LEN_W'(1);
        if (cls == CLS_DIGIT) begin
          // num * 10 + digit, kept modulo 2^16
          num_d = (num_base << 3) + (num_base << 1) + {12'd0, rx_byte_i[3:0]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= CLS_SPACE;
      len_q  <= '0;
    end else begin
      prev_q <= prev_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    if (accept_i && keep && len_base < LEN_W'(MATCH_CHARS)) begin
      chars_q[len_base[MIDX_W-1:0]] <= ch_up;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sctp_cmd_queue.sv */
// Two-entry token queue between the front end and the command executor.
`timescale 1ns / 1ps
`default_nettype none

module sctp_cmd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sctp_pkg::tok_evt_t  data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output sctp_pkg::tok_evt_t  data_o
);
  import sctp_pkg::*;

  tok_evt_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sctp_back.sv */
// Back end: command state, argument handling, range checks and result queue.
`timescale 1ns / 1ps
`default_nettype none

module sctp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          evt_valid_i,
  input  sctp_pkg::tok_evt_t            evt_i,
  output logic                          evt_pop_o,
  input  logic                          cfg_we_i,
  input  logic [sctp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output sctp_pkg::res_t                res_o
);
  import sctp_pkg::*;

  `include "assert_macros.svh"

  logic [15:0] min_q, max_q;
  logic [3:0]  pend_q, pend_d;
  logic        needs_q, needs_d;
  logic [7:0]  sel_q, sel_d;

  res_t        res_mem_q [2];
  logic        res_wr_q, res_rd_q;
  logic [1:0]  res_cnt_q;
  logic        pop_fire, fire;

  logic        exec, servo_ok;
  logic [3:0]  exec_idx;
  logic [15:0] exec_arg;
  res_t        res;

  function automatic logic takes_arg(input logic [3:0] idx);
    return (idx == W_HASH) || (idx == W_P) || (idx == W_S) || (idx == W_T);
  endfunction

  assign pop_fire  = pop_i && (res_cnt_q != 2'd0);
  assign fire      = evt_valid_i && ((res_cnt_q != 2'd2) || pop_fire);
  assign evt_pop_o = fire;
  assign empty_o   = (res_cnt_q == 2'd0);
  assign res_o     = res_mem_q[res_rd_q];
  assign servo_ok  = (sel_q < 8'(SERVO_COUNT));

  always_comb begin
    pend_d   = pend_q;
    needs_d  = needs_q;
    exec     = 1'b0;
    exec_idx = evt_i.word;
    exec_arg = 16'd0;
    if (evt_i.kind == TOK_WORD) begin
      pend_d  = evt_i.word + 4'd1;
      needs_d = takes_arg(evt_i.word);
      exec    = !takes_arg(evt_i.word);
    end else if (evt_i.kind == TOK_NUMBER && pend_q != CMD_NONE && needs_q) begin
      exec     = 1'b1;
      exec_idx = pend_q - 4'd1;
      exec_arg = evt_i.number;
    end

    sel_d       = sel_q;
    res.action  = ACT_NONE;
    res.servo   = 5'd0;
    res.value   = 16'd0;
    res.cmd_end = evt_i.cmd_end;
    if (exec) begin
      case (exec_idx)
        W_HASH: sel_d = exec_arg[7:0];
        W_H: begin
          if (servo_ok) begin
            res.action = ACT_HOLD;
            res.servo  = sel_q[4:0];
          end
        end
        W_L: begin
          if (servo_ok) begin
            res.action = ACT_LIMP;
            res.servo  = sel_q[4:0];
          end
        end
        W_P: begin
          if (servo_ok && exec_arg >= min_q && exec_arg <= max_q) begin
            res.action = ACT_SET_WIDTH;
            res.servo  = sel_q[4:0];
            res.value  = exec_arg;
          end
        end
        W_Q: begin
          if (servo_ok) begin
            res.action = ACT_QUERY_STATUS;
            res.servo  = sel_q[4:0];
          end
        end
        W_QP: begin
          if (servo_ok) begin
            res.action = ACT_QUERY_POS;
            res.servo  = sel_q[4:0];
          end
        end
        W_QV:  res.action = ACT_QUERY_BATT;
        W_S: begin
          if (servo_ok) begin
            res.action = ACT_SET_SPEED;
            res.servo  = sel_q[4:0];
            res.value  = exec_arg;
          end
        end
        W_T: begin
          res.action = ACT_MOVE_TIME;
          res.value  = exec_arg;
        end
        W_VER: res.action = ACT_VERSION;
        default: ;  // current query and unused codes: no action
      endcase
    end

    // carriage return closes the command after its token is handled
    if (evt_i.cmd_end) begin
      pend_d  = CMD_NONE;
      needs_d = 1'b0;
      sel_d   = SEL_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= MIN_PULSE_RST;
      max_q     <= MAX_PULSE_RST;
      pend_q    <= CMD_NONE;
      needs_q   <= 1'b0;
      sel_q     <= SEL_NONE;
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_MIN_PULSE) begin
        min_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CFG_MAX_PULSE) begin
        max_q <= cfg_data_i;
      end
      if (fire) begin
        pend_q   <= pend_d;
        needs_q  <= needs_d;
        sel_q    <= sel_d;
        res_wr_q <= ~res_wr_q;
      end
      if (pop_fire) begin
        res_rd_q <= ~res_rd_q;
      end
      if (fire && !pop_fire) begin
        res_cnt_q <= res_cnt_q + 2'd1;
      end else if (pop_fire && !fire) begin
        res_cnt_q <= res_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_mem_q[res_wr_q] <= res;
    end
  end

  `ASSERT_CLK(a_cr_clears, fire && evt_i.cmd_end |=> pend_q == CMD_NONE && sel_q == SEL_NONE && !needs_q, "carriage return did not clear command state")
  `ASSERT_CLK(a_width_in_range, fire && res.action == ACT_SET_WIDTH |-> res.value >= min_q && res.value <= max_q, "pulse width out of range passed")
  `ASSERT_CLK(a_no_servo_field, fire && (res.action == ACT_NONE || res.action == ACT_MOVE_TIME || res.action == ACT_QUERY_BATT || res.action == ACT_VERSION) |-> res.servo == 5'd0, "servo field set for a servo-less action")
  `ASSERT_NEVER(a_res_overrun, fire && res_cnt_q == 2'd2 && !pop_fire, "result queue overrun")

endmodule

`default_nettype wire

/* hw/rtl/servo_command_token_parser.sv */
// Top level of the servo command token parser: front end, token queue, executor.
`timescale 1ns / 1ps
`default_nettype none

// Servo command token parser. Feed it the serial receive stream one byte per
// transaction on push/full; it returns exactly one action transaction per byte
// on empty/pop, in byte order. Bytes are split into whitespace, digit and other
// runs (letters folded to upper case, at most six characters kept per run).
// Words # H L P Q QC QP QV S T VER are recognized when the run ends; numbers
// are taken modulo 65536 and go to the pending argument command, which stays
// pending until carriage return or the next recognized word. Carriage return
// sets command_end and drops the selected servo and pending command. Throughput
// is one byte per clock while the token queue has room: the front end
// classifies the byte, steps the decimal accumulator and matches the finished
// word in the cycle the byte is taken, and the executor handles one token per
// clock while the result queue has room. Two-entry queues sit between front
// end and executor and on the result side, so either side may stall without
// blocking the other until they fill.
// Configuration writes (index 0 minimum, index 1 maximum pulse width) are
// always ready and must be issued only while no bytes are in flight.

module servo_command_token_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // byte input queue
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     rx_byte_i,
  // result queue
  output logic                           empty,
  input  logic                           pop,
  output logic [3:0]                     action_o,
  output logic [4:0]                     servo_o,
  output logic [15:0]                    value_o,
  output logic                           command_end_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sctp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);
  import sctp_pkg::*;

  logic     in_accept;
  tok_evt_t front_evt, back_evt;
  logic     q_valid, q_pop;
  res_t     res;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = push && !full;

  sctp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .rx_byte_i (rx_byte_i),
    .evt_o     (front_evt)
  );

  // every accepted byte enters the queue, token or not, so results stay 1:1
  sctp_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .data_i  (front_evt),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (back_evt)
  );

  sctp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (q_valid),
    .evt_i       (back_evt),
    .evt_pop_o   (q_pop),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign action_o      = res.action;
  assign servo_o       = res.servo;
  assign value_o       = res.value;
  assign command_end_o = res.cmd_end;

endmodule

`default_nettype wire

/* tb/tb_servo_command_token_parser.sv */
// Testbench for the servo command token parser: byte streams in, predicted action checks out.
`timescale 1ns / 1ps

module tb_servo_command_token_parser;
  import sctp_pkg::*;

  // Character classes the parser splits the byte stream into.
  typedef enum logic [1:0] {
    CLASS_SPACE,
    CLASS_DIGIT,
    CLASS_OTHER
  } char_class_e;

  // Tracks parser state byte by byte and keeps the actions still owed by the DUT.
  class action_scoreboard;
    logic [15:0]  min_width;
    logic [15:0]  max_width;
    char_class_e  prev_class;
    int unsigned  tok_len;
    logic [7:0]   tok_text [TOKEN_CHARS];
    logic [3:0]   pending_cmd;
    bit           needs_arg;
    logic [7:0]   sel_servo;
    res_t         expected_actions [$];
    int           errors;

    function new();
      min_width   = MIN_PULSE_RST;
      max_width   = MAX_PULSE_RST;
      prev_class  = CLASS_SPACE;
      tok_len     = 0;
      pending_cmd = CMD_NONE;
      needs_arg   = 1'b0;
      sel_servo   = SEL_NONE;
      errors      = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      if (idx == CFG_MIN_PULSE) min_width = data;
      else if (idx == CFG_MAX_PULSE) max_width = data;
    endfunction

    // Exact match of the kept token against the command words.
    function bit match_word(output logic [3:0] idx);
      match_word = 1'b1;
      idx = CMD_NONE;
      if (tok_len == 1) begin
        case (tok_text[0])
          "#": idx = W_HASH;
          "H": idx = W_H;
          "L": idx = W_L;
          "P": idx = W_P;
          "Q": idx = W_Q;
          "S": idx = W_S;
          "T": idx = W_T;
          default: match_word = 1'b0;
        endcase
      end else if (tok_len == 2 && tok_text[0] == "Q") begin
        case (tok_text[1])
          "C": idx = W_QC;
          "P": idx = W_QP;
          "V": idx = W_QV;
          default: match_word = 1'b0;
        endcase
      end else if (tok_len == 3 && tok_text[0] == "V" && tok_text[1] == "E" &&
                   tok_text[2] == "R") begin
        idx = W_VER;
      end else begin
        match_word = 1'b0;
      end
    endfunction

    function void run_command(logic [3:0] idx, logic [15:0] arg, inout res_t r);
      bit servo_ok;
      servo_ok = sel_servo < SERVO_COUNT;
      case (idx)
        W_HASH: sel_servo = arg[7:0];
        W_H: if (servo_ok) begin
          r.action = ACT_HOLD;
          r.servo  = sel_servo[4:0];
        end
        W_L: if (servo_ok) begin
          r.action = ACT_LIMP;
          r.servo  = sel_servo[4:0];
        end
        W_P: if (servo_ok && arg >= min_width && arg <= max_width) begin
          r.action = ACT_SET_WIDTH;
          r.servo  = sel_servo[4:0];
          r.value  = arg;
        end
        W_Q: if (servo_ok) begin
          r.action = ACT_QUERY_STATUS;
          r.servo  = sel_servo[4:0];
        end
        W_QP: if (servo_ok) begin
          r.action = ACT_QUERY_POS;
          r.servo  = sel_servo[4:0];
        end
        W_QV: r.action = ACT_QUERY_BATT;
        W_S: if (servo_ok) begin
          r.action = ACT_SET_SPEED;
          r.servo  = sel_servo[4:0];
          r.value  = arg;
        end
        W_T: begin
          r.action = ACT_MOVE_TIME;
          r.value  = arg;
        end
        W_VER: r.action = ACT_VERSION;
        default: ;
      endcase
    endfunction

    // One accepted byte -> exactly one expected action.
    function void note_byte(logic [7:0] rx);
      logic [7:0]  ch;
      char_class_e cls;
      res_t        r;
      logic [3:0]  idx;
      logic [15:0] num;
      ch = rx;
      if (ch == 8'h20 || (ch >= 8'h09 && ch <= CH_CR)) begin
        cls = CLASS_SPACE;
      end else if (ch >= "0" && ch <= "9") begin
        cls = CLASS_DIGIT;
      end else begin
        cls = CLASS_OTHER;
        if (ch >= "a" && ch <= "z") ch = ch - 8'd32;
      end
      r = '0;
      if (cls != prev_class) begin
        if (prev_class == CLASS_OTHER) begin
          if (match_word(idx)) begin
            pending_cmd = idx + 4'd1;
            needs_arg = (idx == W_HASH || idx == W_P || idx == W_S || idx == W_T);
            if (!needs_arg) run_command(idx, 16'd0, r);
          end
        end else if (prev_class == CLASS_DIGIT) begin
          // 16-bit accumulate wraps modulo 65536
          num = '0;
          for (int k = 0; k < tok_len; k++) num = num * 16'd10 + {8'h00, tok_text[k] - 8'h30};
          if (pending_cmd != CMD_NONE && needs_arg) run_command(pending_cmd - 4'd1, num, r);
        end
        tok_len = 0;
        prev_class = cls;
      end
      if (cls != CLASS_SPACE && tok_len < TOKEN_CHARS) begin
        tok_text[tok_len] = ch;
        tok_len++;
      end
      // carriage return closes the command line
      if (ch == CH_CR) begin
        pending_cmd = CMD_NONE;
        sel_servo   = SEL_NONE;
        needs_arg   = 1'b0;
      end
      r.cmd_end = (ch == CH_CR);
      expected_actions.push_back(r);
    endfunction

    function void mismatch(string field, int unsigned want, logic [15:0] got);
      errors++;
      if (errors <= 100)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_action(logic [3:0] a, logic [4:0] s, logic [15:0] v, logic e);
      res_t want;
      if (expected_actions.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t: unexpected action, expected none, actual %0d/%0d/%0d/%0d",
                   $time, a, s, v, e);
        return;
      end
      want = expected_actions.pop_front();
      if (a !== want.action)  mismatch("action", want.action, a);
      if (s !== want.servo)   mismatch("servo", want.servo, s);
      if (v !== want.value)   mismatch("value", want.value, v);
      if (e !== want.cmd_end) mismatch("command_end", want.cmd_end, e);
    endfunction

    function int outstanding();
      return expected_actions.size();
    endfunction
  endclass

  // DUT connections; every input starts at a known value.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 push        = 1'b0;
  logic [7:0]           rx_byte     = 8'h00;
  logic                 pop         = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_MIN_PULSE;
  logic [15:0]          cfg_data    = 16'h0000;
  logic                 full;
  logic                 empty;
  logic [3:0]           action;
  logic [4:0]           servo;
  logic [15:0]          value;
  logic                 command_end;
  logic                 cfg_ready;

  action_scoreboard sb;

  // Idle rates in percent; rx_hold forces a long receiver stall.
  int unsigned sender_idle_pct = 0;
  int unsigned rx_stall_pct    = 0;
  logic        rx_hold         = 1'b0;

  // Stimulus of the current phase, and the pulse range it is built against.
  logic [7:0]  stim_bytes [$];
  int unsigned pulse_lo = MIN_PULSE_RST;
  int unsigned pulse_hi = MAX_PULSE_RST;

  // Command words plus a few unknown ones; the last is longer than a token.
  string command_words [15] = '{"#", "H", "L", "P", "Q", "QC", "QP", "QV", "S", "T", "VER",
                                "X", "QQ", "VERS", "HOLDALL"};

  servo_command_token_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .rx_byte_i     (rx_byte),
    .empty         (empty),
    .pop           (pop),
    .action_o      (action),
    .servo_o       (servo),
    .value_o       (value),
    .command_end_o (command_end),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: check each popped action, then pick next cycle's pop.
  // Values read here are the ones sampled at this edge.
  always @(posedge clk_i) begin
    if (pop && !empty) sb.check_action(action, servo, value, command_end);
    if (rx_hold || $urandom_range(99, 0) < rx_stall_pct) pop <= 1'b0;
    else pop <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] b);
    stim_bytes.push_back(b);
  endfunction

  // Letters go out in random case; the parser folds them to upper.
  function automatic void add_word(string w);
    logic [7:0] c;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (c >= "A" && c <= "Z" && $urandom_range(1, 0) == 1) c = c + 8'd32;
      add_byte(c);
    end
  endfunction

  // Whitespace of every kind the parser knows, carriage return aside.
  function automatic void add_sep();
    int unsigned n;
    n = ($urandom_range(9, 0) == 0) ? 2 : 1;
    repeat (n) begin
      case ($urandom_range(5, 0))
        0: add_byte(8'h09);
        1: add_byte(8'h0A);
        2: add_byte(8'h0B);
        3: add_byte(8'h0C);
        default: add_byte(8'h20);
      endcase
    end
  endfunction

  // Decimal text, sometimes with leading zeros or past the kept length.
  function automatic void add_number(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    case ($urandom_range(19, 0))
      0: s = {"00", s};
      1: s = {s, $sformatf("%0d", $urandom_range(999, 0))};
      default: ;
    endcase
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // Pulse widths hug the configured bounds.
  function automatic int unsigned pick_width();
    int unsigned w;
    case ($urandom_range(5, 0))
      0: w = pulse_lo;
      1: w = pulse_hi;
      2: w = pulse_lo - 1;
      3: w = pulse_hi + 1;
      4: w = $urandom_range(65535, 0);
      default: w = $urandom_range(pulse_hi, pulse_lo);
    endcase
    return w & 32'hFFFF;
  endfunction

  function automatic int unsigned pick_servo();
    case ($urandom_range(9, 0))
      0, 1: return $urandom_range(255, 32);
      2: return $urandom_range(65535, 0);
      default: return $urandom_range(31, 0);
    endcase
  endfunction

  // One command line: mostly well formed, some raw noise.
  function automatic void add_command();
    string       w;
    int unsigned nwords;
    if ($urandom_range(99, 0) < 10) begin
      repeat ($urandom_range(6, 1)) add_byte($urandom_range(255, 0));
      return;
    end
    if ($urandom_range(99, 0) < 85) begin
      add_word("#");
      add_number(pick_servo());
      add_sep();
    end
    nwords = $urandom_range(3, 1);
    repeat (nwords) begin
      w = command_words[$urandom_range(14, 0)];
      add_word(w);
      if (w == "P" || w == "S" || w == "T" || w == "#") begin
        // argument commands stay pending, so a second number applies again
        for (int j = 0; j < $urandom_range(2, 1); j++) begin
          if (j > 0 || $urandom_range(1, 0) == 1) add_sep();
          if (w == "P") add_number(pick_width());
          else if (w == "#") add_number(pick_servo());
          else add_number($urandom_range(65535, 0));
        end
      end else if ($urandom_range(9, 0) == 0) begin
        add_sep();
        add_number($urandom_range(2000, 0));
      end
      add_sep();
    end
    if ($urandom_range(9, 0) != 0) add_byte(CH_CR);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic wait_drain();
    while (sb.outstanding() != 0) @(posedge clk_i);
    // after the last expected action is checked, let the pipe settle
    repeat (4) @(posedge clk_i);
  endtask

  // Both pulse registers in back-to-back transactions; valid stays high between.
  task automatic write_pulse_range(logic [15:0] lo, logic [15:0] hi);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 2; i++) begin
      cfg_index <= (i == 0) ? CFG_MIN_PULSE : CFG_MAX_PULSE;
      cfg_data  <= (i == 0) ? lo : hi;
      do @(posedge clk_i); while (!cfg_ready);
      sb.set_register((i == 0) ? CFG_MIN_PULSE : CFG_MAX_PULSE, (i == 0) ? lo : hi);
    end
    cfg_valid <= 1'b0;
    pulse_lo = lo;
    pulse_hi = hi;
  endtask

  // Long receiver hold-off in its own process so the sender keeps pushing.
  task automatic rx_hold_off(int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  endtask

  // Push the phase's bytes; pause_at >= 0 stops the sender until all is drained.
  task automatic send_bytes(int pause_at);
    for (int i = 0; i < stim_bytes.size(); i++) begin
      if (i == pause_at) begin
        push <= 1'b0;
        do @(posedge clk_i); while (sb.outstanding() != 0);
      end
      while ($urandom_range(99, 0) < sender_idle_pct) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
      push    <= 1'b1;
      rx_byte <= stim_bytes[i];
      do @(posedge clk_i); while (full);
      sb.note_byte(stim_bytes[i]);
    end
    push <= 1'b0;
    stim_bytes.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  // Phase table: pulse range per phase; idle mode rotates sender, receiver,
  // both, none. min above max shuts every width out.
  int unsigned lo_tab [7] = '{0, 2000, 1000, 0, 65535, 500, 300};
  int unsigned hi_tab [7] = '{65535, 1000, 2000, 0, 65535, 2500, 3000};

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: servo 31 with width at the reset minimum, top speed, limp;
    // an over-long number that selects an out-of-range servo; the no-argument
    // queries QP, QC and QV, version, a zero move time, an unknown word; extreme bytes.
    add_word("#31P500S65535L");
    add_byte(CH_CR);
    add_word("#1234567qp9");
    add_byte(CH_CR);
    add_word("qc QV VeR t0 zZ");
    add_byte(CH_CR);
    add_byte(8'h00);
    add_byte(8'hFF);
    send_bytes(-1);

    for (int ph = 0; ph < 7; ph++) begin
      wait_drain();
      write_pulse_range(lo_tab[ph], hi_tab[ph]);
      case ((ph + 1) % 4)
        0: begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin sender_idle_pct = 82; rx_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  rx_stall_pct = 82; end
        default: begin sender_idle_pct = 24; rx_stall_pct = 24; end
      endcase
      while (stim_bytes.size() < 75) add_command();
      // full-rate phase: stall the receiver long enough to back up the input
      if (ph == 3) fork rx_hold_off(80); join_none
      send_bytes((ph == 2) ? 37 : -1);
    end

    wait_drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_servo_command_token_parser: done, clean");
    end else begin
      $display("tb_servo_command_token_parser: done, errors");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb_servo_command_token_parser: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sctp_pkg.sv
hw/rtl/sctp_front.sv
hw/rtl/sctp_cmd_queue.sv
hw/rtl/sctp_back.sv
hw/rtl/servo_command_token_parser.sv
tb/tb_servo_command_token_parser.sv
